### hw/rtl/smw_pkg.sv
// Shared constants, types and helper functions of the SPI master word shifter.
package smw_pkg;

	localparam int MAX_WORD_BITS = 32;
	localparam int DIVIDER_BITS  = 9;
	localparam int COUNT_BITS    = $clog2(MAX_WORD_BITS + 1);
	localparam int INDEX_BITS    = $clog2(MAX_WORD_BITS);
	localparam int APB_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 32;

	typedef logic [MAX_WORD_BITS-1:0] word_t;
	typedef logic [DIVIDER_BITS-1:0]  div_t;
	typedef logic [COUNT_BITS-1:0]    count_t;
	typedef logic [INDEX_BITS-1:0]    index_t;

	// Word length codes; the reserved code falls back to 8 bits.
	typedef enum logic [1:0] {
		WLEN_8  = 2'd0,
		WLEN_16 = 2'd1,
		WLEN_32 = 2'd2,
		WLEN_RSV = 2'd3
	} wlen_t;

	// Register index, taken from paddr[3:2].
	typedef enum logic [1:0] {
		REG_ENABLE  = 2'd0,
		REG_DIVIDER = 2'd1,
		REG_WLEN    = 2'd2,
		REG_MODE    = 2'd3
	} reg_idx_t;

	localparam logic FUNC_LOAD = 1'b1;

	function automatic count_t word_bits(input wlen_t wlen);
		count_t n;
		unique case (wlen)
			WLEN_16: n = count_t'(16);
			WLEN_32: n = count_t'(MAX_WORD_BITS);
			default: n = count_t'(8);
		endcase
		return n;
	endfunction

	function automatic word_t word_mask(input wlen_t wlen);
		word_t m;
		unique case (wlen)
			WLEN_16: m = word_t'(32'h0000_FFFF);
			WLEN_32: m = '1;
			default: m = word_t'(32'h0000_00FF);
		endcase
		return m;
	endfunction

	function automatic index_t msb_index(input wlen_t wlen);
		count_t n;
		n = word_bits(wlen);
		return index_t'(n - count_t'(1));
	endfunction

endpackage

### hw/rtl/smw_if.sv
// Valid/ready channel interfaces for the tick input and the result output.
interface smw_tick_if;
	logic                 valid;
	logic                 ready;
	logic                 func;
	smw_pkg::word_t       tx_word;
	logic                 miso;

	modport source (output valid, func, tx_word, miso, input ready);
	modport sink   (input valid, func, tx_word, miso, output ready);
endinterface

interface smw_result_if;
	logic                 valid;
	logic                 ready;
	logic                 sck;
	logic                 mosi;
	logic                 busy_res;
	logic                 rx_valid;
	smw_pkg::word_t       rx_word;

	modport source (output valid, sck, mosi, busy_res, rx_valid, rx_word, input ready);
	modport sink   (input valid, sck, mosi, busy_res, rx_valid, rx_word, output ready);
endinterface

### hw/rtl/spi_master_word_shifter.sv
// SPI master word shifter: one peripheral clock tick per transfer on the input channel.
//
// Each input transfer is one tick of the serial engine and produces exactly one result
// transfer carrying SCK, MOSI, busy and, on the tick a word completes, the received word.
// The block sustains one tick per clock cycle while the result side accepts; a tick passes
// through an input register and then a result register, and both registers advance
// together whenever the result side accepts or is empty. Registers at byte addresses 0, 4,
// 8 and 12 hold enable, divider, word length and clock mode; they are meant to be written
// only while no ticks are in flight.
module spi_master_word_shifter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	smw_tick_if.sink                             req,
	smw_result_if.source                         rsp,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [smw_pkg::APB_ADDR_BITS-1:0]    paddr,
	input  logic [smw_pkg::APB_DATA_BITS-1:0]    pwdata,
	output logic [smw_pkg::APB_DATA_BITS-1:0]    prdata,
	output logic                                 pready
);

	// Configuration registers.
	logic                 enable_q;
	smw_pkg::div_t        div_q;
	smw_pkg::wlen_t       wlen_q;
	logic [1:0]           mode_q;

	// Input stage.
	logic                 valid_s1;
	logic                 func_s1;
	smw_pkg::word_t       tx_s1;
	logic                 miso_s1;

	// Engine state.
	smw_pkg::div_t        tick_q;
	smw_pkg::count_t      bits_q;
	smw_pkg::word_t       txsh_q;
	smw_pkg::word_t       rxsh_q;
	logic                 level_q;
	logic                 active_q;

	// Result register.
	logic                 out_valid_q;
	logic                 sck_q;
	logic                 mosi_q;
	logic                 busy_q;
	logic                 rxv_q;
	smw_pkg::word_t       rxw_q;

	logic                 advance;
	logic                 step;
	logic                 wr_en;
	smw_pkg::reg_idx_t    reg_idx;

	smw_pkg::count_t      n;
	smw_pkg::word_t       mask;
	logic                 idle_lvl;
	logic                 late;
	logic                 at_idle;
	logic                 finish;

	smw_pkg::div_t        tick_n;
	smw_pkg::count_t      bits_n;
	smw_pkg::word_t       txsh_n;
	smw_pkg::word_t       rxsh_n;
	logic                 level_n;
	logic                 active_n;
	logic                 mosi_n;
	logic                 rxv_n;
	smw_pkg::word_t       rxw_n;

	assign pready  = 1'b1;
	assign reg_idx = smw_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_comb begin
		unique case (reg_idx)
			smw_pkg::REG_ENABLE:  prdata = {{(smw_pkg::APB_DATA_BITS-1){1'b0}}, enable_q};
			smw_pkg::REG_DIVIDER: prdata = {{(smw_pkg::APB_DATA_BITS-smw_pkg::DIVIDER_BITS){1'b0}},
				div_q};
			smw_pkg::REG_WLEN:    prdata = {{(smw_pkg::APB_DATA_BITS-2){1'b0}}, wlen_q};
			default:              prdata = {{(smw_pkg::APB_DATA_BITS-2){1'b0}}, mode_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			div_q    <= '0;
			wlen_q   <= smw_pkg::WLEN_8;
			mode_q   <= 2'b00;
		end else if (wr_en) begin
			unique case (reg_idx)
				smw_pkg::REG_ENABLE:  enable_q <= pwdata[0];
				smw_pkg::REG_DIVIDER: div_q    <= pwdata[smw_pkg::DIVIDER_BITS-1:0];
				smw_pkg::REG_WLEN:    wlen_q   <= smw_pkg::wlen_t'(pwdata[1:0]);
				default:              mode_q   <= pwdata[1:0];
			endcase
		end
	end

	// Both stages move together whenever the result register is free or being taken.
	assign advance   = !out_valid_q || rsp.ready;
	assign req.ready = !valid_s1 || advance;
	assign step      = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			func_s1 <= req.func;
			tx_s1   <= req.tx_word;
			miso_s1 <= req.miso;
		end
	end

	assign n        = smw_pkg::word_bits(wlen_q);
	assign mask     = smw_pkg::word_mask(wlen_q);
	assign idle_lvl = mode_q[1];
	assign late     = mode_q[0];
	assign at_idle  = (level_q == idle_lvl);

	always_comb begin
		tick_n   = tick_q;
		bits_n   = bits_q;
		txsh_n   = txsh_q;
		rxsh_n   = rxsh_q;
		level_n  = level_q;
		active_n = active_q;
		finish   = 1'b0;
		rxv_n    = 1'b0;
		rxw_n    = '0;
		if (!enable_q) begin
			active_n = 1'b0;
			tick_n   = '0;
			bits_n   = '0;
			level_n  = idle_lvl;
		end else if (!active_q) begin
			level_n = idle_lvl;
			if (func_s1 == smw_pkg::FUNC_LOAD) begin
				txsh_n   = tx_s1 & mask;
				rxsh_n   = '0;
				bits_n   = n;
				tick_n   = '0;
				active_n = 1'b1;
			end
		end else if (tick_q < div_q) begin
			tick_n = tick_q + smw_pkg::div_t'(1);
		end else begin
			tick_n = '0;
			if (!late) begin
				// Data changes on the trailing edge: sample and count there.
				level_n = !level_q;
				if (!at_idle) begin
					rxsh_n = {rxsh_q[smw_pkg::MAX_WORD_BITS-2:0], miso_s1};
					txsh_n = {txsh_q[smw_pkg::MAX_WORD_BITS-2:0], 1'b0};
					bits_n = bits_q - smw_pkg::count_t'(1);
					finish = (bits_n == '0);
				end
			end else if (at_idle && bits_q == '0) begin
				// Final idle half period samples the last bit.
				rxsh_n = {rxsh_q[smw_pkg::MAX_WORD_BITS-2:0], miso_s1};
				txsh_n = {txsh_q[smw_pkg::MAX_WORD_BITS-2:0], 1'b0};
				finish = 1'b1;
			end else if (at_idle) begin
				level_n = !level_q;
				// The first leading edge only starts the clock.
				if (bits_q < n) begin
					rxsh_n = {rxsh_q[smw_pkg::MAX_WORD_BITS-2:0], miso_s1};
					txsh_n = {txsh_q[smw_pkg::MAX_WORD_BITS-2:0], 1'b0};
				end
			end else begin
				level_n = !level_q;
				bits_n  = bits_q - smw_pkg::count_t'(1);
			end
			if (finish) begin
				rxv_n    = 1'b1;
				rxw_n    = rxsh_n & mask;
				active_n = 1'b0;
				level_n  = idle_lvl;
			end
		end
		mosi_n = active_n ? txsh_n[smw_pkg::msb_index(wlen_q)] : 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			bits_q   <= '0;
			txsh_q   <= '0;
			rxsh_q   <= '0;
			level_q  <= 1'b0;
			active_q <= 1'b0;
		end else if (step) begin
			tick_q   <= tick_n;
			bits_q   <= bits_n;
			txsh_q   <= txsh_n;
			rxsh_q   <= rxsh_n;
			level_q  <= level_n;
			active_q <= active_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			sck_q  <= level_n;
			mosi_q <= mosi_n;
			busy_q <= active_n;
			rxv_q  <= rxv_n;
			rxw_q  <= rxw_n;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.sck      = sck_q;
	assign rsp.mosi     = mosi_q;
	assign rsp.busy_res = busy_q;
	assign rsp.rx_valid = rxv_q;
	assign rsp.rx_word  = rxw_q;

endmodule

### hw/rtl/smw_checker.sv
// Port-level checks for the SPI master word shifter and their bind.
module smw_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  rsp_valid,
	input logic                  rsp_ready,
	input logic                  sck,
	input logic                  mosi,
	input logic                  busy_res,
	input logic                  rx_valid,
	input smw_pkg::word_t        rx_word
);

	// A completed word always ends the transfer in the same result.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rx_valid |-> !busy_res)
		else $error("rx_valid with busy_res set");

	// MOSI rests low whenever no word is being shifted.
	a_idle_mosi: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !busy_res |-> !mosi)
		else $error("mosi high while idle");

	// The received word is zero except on a completing tick.
	a_rx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rx_valid |-> rx_word == '0)
		else $error("rx_word nonzero without rx_valid");

	// A stalled result holds its fields.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(sck) && $stable(mosi)
			&& $stable(busy_res) && $stable(rx_valid) && $stable(rx_word))
		else $error("stalled result changed");

endmodule

bind spi_master_word_shifter smw_checker u_smw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.sck       (rsp.sck),
	.mosi      (rsp.mosi),
	.busy_res  (rsp.busy_res),
	.rx_valid  (rsp.rx_valid),
	.rx_word   (rsp.rx_word)
);
